### hw/rtl/tile_map_ray_caster_top_assert.svh
// Assertion macros for the ray caster
`ifndef TILE_MAP_RAY_CASTER_TOP_ASSERT_SVH
`define TILE_MAP_RAY_CASTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TMRC_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define TMRC_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define TMRC_ASSERT_IMP(label, clk, rst_n, a, c)
`define TMRC_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

### hw/rtl/tmrc_pkg.sv
`default_nettype none
package tmrc_pkg;
  typedef struct packed {
    logic        kind;
    logic [3:0]  map_row;
    logic [15:0] row_walls;
    logic [15:0] camera_x;
    logic [15:0] camera_y;
    logic [11:0] camera_angle;
    logic [6:0]  column;
  } in_beat_t;

  typedef struct packed {
    logic signed [10:0] ceiling_row;
    logic [9:0]         floor_row;
    logic [2:0]         shade;
    logic [7:0]         hit_steps;
    logic               left_map;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_ANG, ST_SIN, ST_COS, ST_MARCH, ST_CDIV, ST_DONE
  } state_t;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_FOV    = 2'd2;
  localparam logic [1:0] CFG_DEPTH  = 2'd3;
  localparam logic       KIND_MAP   = 1'b0;

  function automatic logic [14:0] sine_tab(input logic [6:0] i);
    logic [14:0] v;
    case (i)
      7'd0: v=15'd0; 7'd1: v=15'd402; 7'd2: v=15'd804; 7'd3: v=15'd1205;
      7'd4: v=15'd1606; 7'd5: v=15'd2006; 7'd6: v=15'd2404; 7'd7: v=15'd2801;
      7'd8: v=15'd3196; 7'd9: v=15'd3590; 7'd10: v=15'd3981; 7'd11: v=15'd4370;
      7'd12: v=15'd4756; 7'd13: v=15'd5139; 7'd14: v=15'd5520; 7'd15: v=15'd5897;
      7'd16: v=15'd6270; 7'd17: v=15'd6639; 7'd18: v=15'd7005; 7'd19: v=15'd7366;
      7'd20: v=15'd7723; 7'd21: v=15'd8076; 7'd22: v=15'd8423; 7'd23: v=15'd8765;
      7'd24: v=15'd9102; 7'd25: v=15'd9434; 7'd26: v=15'd9760; 7'd27: v=15'd10080;
      7'd28: v=15'd10394; 7'd29: v=15'd10702; 7'd30: v=15'd11003; 7'd31: v=15'd11297;
      7'd32: v=15'd11585; 7'd33: v=15'd11866; 7'd34: v=15'd12140; 7'd35: v=15'd12406;
      7'd36: v=15'd12665; 7'd37: v=15'd12916; 7'd38: v=15'd13160; 7'd39: v=15'd13395;
      7'd40: v=15'd13623; 7'd41: v=15'd13842; 7'd42: v=15'd14053; 7'd43: v=15'd14255;
      7'd44: v=15'd14449; 7'd45: v=15'd14635; 7'd46: v=15'd14811; 7'd47: v=15'd14978;
      7'd48: v=15'd15137; 7'd49: v=15'd15286; 7'd50: v=15'd15426; 7'd51: v=15'd15557;
      7'd52: v=15'd15679; 7'd53: v=15'd15791; 7'd54: v=15'd15893; 7'd55: v=15'd15986;
      7'd56: v=15'd16069; 7'd57: v=15'd16143; 7'd58: v=15'd16207; 7'd59: v=15'd16261;
      7'd60: v=15'd16305; 7'd61: v=15'd16340; 7'd62: v=15'd16364; 7'd63: v=15'd16379;
      default: v=15'd16384;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

### hw/rtl/tile_map_ray_caster_top.sv
// Map writes are taken with no result. A cast runs, after its beat is taken, through a divide for the
// ray angle on the shared restoring divider, the set-up states ST_ANG, ST_SIN and ST_COS, the
// march with one step per cycle for 1 to depth_steps steps (at most 255), a second divide on
// the same divider, and ST_DONE, after which the result is valid. in_stall is high from a cast's
// acceptance until its result is taken. Map writes can follow back to back while no cast is in flight.
// Reset (rst_n, synchronous): registers take 120/40/512/160, all map cells open, no result pending.
`default_nettype none
`include "tile_map_ray_caster_top_assert.svh"
module tile_map_ray_caster_top #(
  parameter int MAP_SIZE    = 16,
  parameter int ANGLE_BITS  = 12,
  parameter int MAX_COLUMNS = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tmrc_pkg::in_beat_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tmrc_pkg::out_beat_t     out_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [11:0]        cfg_wdata
);
  import tmrc_pkg::*;

  localparam int AB  = ANGLE_BITS;
  localparam int FB  = AB - 8;
  localparam int MSW = (MAP_SIZE > 16) ? 16 : MAP_SIZE;
  localparam int RB  = $clog2(MAP_SIZE);
  localparam int CB  = $clog2(MAX_COLUMNS + 1);
  localparam int NUMB = 34;
  localparam int QB  = 34;
  localparam int DB  = 24;

  logic [7:0]  width_r, depth_r, width_nxt, depth_nxt;
  logic [6:0]  height_r, height_nxt;
  logic [11:0] fov_r, fov_nxt;
  logic [MSW-1:0] map_r [MAP_SIZE];

  state_t state_r, state_nxt;
  in_beat_t item_r;
  out_beat_t res_r;
  logic      out_valid_r;

  logic [NUMB-1:0] rem_r;
  logic [QB-1:0]   quo_r;
  logic [DB-1:0]   den_r;
  logic [5:0]      cnt_r;
  logic            neg_r;
  logic [AB-1:0]   ray_r;
  logic signed [15:0] dx_r, dy_r;
  logic signed [23:0] px_r, py_r;
  logic [7:0]      k_r, dep_r;
  logic            left_r;
  logic signed [15:0] sv;

  wire in_acc  = in_valid && !in_stall;
  wire out_acc = out_valid_r && !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  logic [CB-1:0] wcl;
  always_comb begin
    if (width_r == 8'd0) wcl = CB'(1);
    else if (int'(width_r) > MAX_COLUMNS) wcl = CB'(MAX_COLUMNS);
    else wcl = CB'(width_r);
  end

  // sine unit, one evaluation per cycle
  always_comb begin
    logic [AB-1:0] a;
    logic [1:0]    quad;
    logic [AB-2:0] pos;
    logic [6:0]    idx;
    logic [FB:0]   frac;
    logic [14:0]   lo, hi, v;
    logic [30:0]   prod;
    a = (state_r == ST_COS) ? AB'(ray_r + AB'(1 << (AB - 2))) : ray_r;
    quad = a[AB-1:AB-2];
    pos = {1'b0, a[AB-3:0]};
    if (quad[0]) pos = (AB-1)'(1 << (AB - 2)) - pos;
    idx = 7'(pos >> FB);
    frac = (FB+1)'(pos & (AB-1)'((1 << FB) - 1));
    lo = sine_tab(idx);
    hi = sine_tab(7'(idx + 7'd1));
    prod = 31'(hi - lo) * 31'(frac);
    if (idx >= 7'd64) v = sine_tab(7'd64);
    else v = 15'(lo + 15'(prod >> FB));
    sv = quad[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  end

  // march sample test; cell is sample / (5 * 2^15), the fifth by reciprocal multiply
  logic          s_left, s_hit;
  logic signed [23:0] npx, npy;
  always_comb begin
    logic [8:0]  qx, qy;
    logic [16:0] mx, my;
    logic [6:0]  tx, ty;
    npx = px_r + 24'(dx_r);
    npy = py_r + 24'(dy_r);
    s_left = 1'b0;
    s_hit = 1'b0;
    qx = npx[23:15];
    qy = npy[23:15];
    mx = 17'(qx) * 17'd205;
    my = 17'(qy) * 17'd205;
    tx = mx[16:10];
    ty = my[16:10];
    if (npx < 0 || npy < 0) s_left = 1'b1;
    else if (int'(qx) >= 5 * MAP_SIZE || int'(qy) >= 5 * MAP_SIZE) s_left = 1'b1;
    else if (tx < 7'(MSW)) s_hit = map_r[RB'(ty)][tx[$clog2(MSW)-1:0]];
  end

  wire [NUMB-1:0] trial = {rem_r[NUMB-2:0], quo_r[QB-1]};
  wire            fits  = trial >= NUMB'(den_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && in_data.kind != KIND_MAP) state_nxt = ST_DIV;
      ST_DIV:   if (cnt_r == 6'd0) state_nxt = ST_ANG;
      ST_ANG:   state_nxt = ST_SIN;
      ST_SIN:   state_nxt = ST_COS;
      ST_COS:   state_nxt = ST_MARCH;
      ST_MARCH: if (s_left || s_hit || k_r + 8'd1 >= dep_r) state_nxt = ST_CDIV;
      ST_CDIV:  if (cnt_r == 6'd0) state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    width_nxt = width_r; height_nxt = height_r; fov_nxt = fov_r; depth_nxt = depth_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_nxt  = cfg_wdata[7:0];
        CFG_HEIGHT: height_nxt = cfg_wdata[6:0];
        CFG_FOV:    fov_nxt    = cfg_wdata;
        CFG_DEPTH:  depth_nxt  = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 8'd120; height_r <= 7'd40; fov_r <= 12'd512; depth_r <= 8'd160;
      state_r <= ST_IDLE; out_valid_r <= 1'b0;
      for (int i = 0; i < MAP_SIZE; i++) map_r[i] <= '0;
    end else begin
      width_r <= width_nxt; height_r <= height_nxt; fov_r <= fov_nxt; depth_r <= depth_nxt;
      state_r <= state_nxt;
      if (out_acc) out_valid_r <= 1'b0;
      if (state_r == ST_DONE) out_valid_r <= 1'b1;
      if (in_acc && in_data.kind == KIND_MAP && int'(in_data.map_row) < MAP_SIZE)
        map_r[RB'(in_data.map_row)] <= MSW'(in_data.row_walls);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (in_acc) begin
        logic signed [NUMB:0] n;
        item_r <= in_data;
        n = $signed((NUMB+1)'(2 * in_data.column * fov_r))
          - $signed((NUMB+1)'(fov_r * wcl));
        neg_r <= n[NUMB];
        // floor division via |n| + (neg ? den-1 : 0)
        quo_r <= n[NUMB] ? QB'(-n + (NUMB+1)'(2 * wcl - 1)) : QB'(n);
        rem_r <= '0;
        den_r <= DB'(2 * wcl);
        cnt_r <= 6'(QB - 1);
        dep_r <= (depth_r == 8'd0) ? 8'd1 : depth_r;
      end
      ST_DIV, ST_CDIV: begin
        rem_r <= fits ? trial - NUMB'(den_r) : trial;
        quo_r <= {quo_r[QB-2:0], fits};
        cnt_r <= cnt_r - 6'd1;
      end
      ST_ANG: ray_r <= neg_r ? AB'(item_r.camera_angle - AB'(quo_r))
                             : AB'(item_r.camera_angle + AB'(quo_r));
      ST_SIN: dx_r <= sv;
      ST_COS: begin
        dy_r <= sv;
        px_r <= $signed({2'b0, 22'(item_r.camera_x * 40)});
        py_r <= $signed({2'b0, 22'(item_r.camera_y * 40)});
        k_r <= '0; left_r <= 1'b0;
      end
      ST_MARCH: begin
        logic [7:0] kk;
        logic signed [16:0] num;
        kk = (s_left) ? dep_r : k_r + 8'd1;
        px_r <= npx; py_r <= npy;
        k_r <= kk; left_r <= s_left;
        num = $signed(17'(height_r * (kk - 8'd20)));
        if (kk < 8'd20) num = -$signed(17'(height_r * (8'd20 - kk)));
        neg_r <= num[16];
        quo_r <= num[16] ? QB'(-num) : QB'(num);
        rem_r <= '0;
        den_r <= DB'(2 * kk);
        cnt_r <= 6'(QB - 1);
      end
      ST_DONE: begin
        logic signed [10:0] c;
        c = neg_r ? -$signed(11'(quo_r)) : $signed(11'(quo_r));
        res_r.ceiling_row <= c;
        res_r.floor_row <= 10'($signed({4'b0, height_r}) - c);
        res_r.hit_steps <= k_r;
        res_r.left_map <= left_r;
        if (10'(k_r) * 4 <= 10'(dep_r)) res_r.shade <= 3'd4;
        else if (10'(k_r) * 3 < 10'(dep_r)) res_r.shade <= 3'd3;
        else if (10'(k_r) * 2 < 10'(dep_r)) res_r.shade <= 3'd2;
        else if (k_r < dep_r) res_r.shade <= 3'd1;
        else res_r.shade <= 3'd0;
      end
      default: ;
    endcase
  end

  `TMRC_ASSERT_IMP(a_stall_busy, clk, rst_n, state_r != ST_IDLE, in_stall)
  `TMRC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid_r && out_stall, out_valid_r && $stable(res_r))
  `TMRC_ASSERT_IMP(a_k_bound, clk, rst_n, state_r == ST_DONE, k_r <= dep_r)
endmodule
`default_nettype wire
